// ===== sv/greedy_coin_change_top_defines.svh =====
// Assertion helpers, clocked on clock and disabled during reset.
`ifndef GREEDY_COIN_CHANGE_TOP_DEFINES_SVH
`define GREEDY_COIN_CHANGE_TOP_DEFINES_SVH

`define GCC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define GCC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/gcc_pkg.sv =====
`default_nettype none

package gcc_pkg;

   localparam int CFG_BITS           = 16;
   localparam int CSR_INDEX_BITS     = 3;
   localparam int TYPES_BITS         = 3;
   localparam int COIN_REGS          = 5;
   localparam int NUM_TYPES_DEFAULT  = 5;
   localparam int VALUE_BITS_DEFAULT = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TYPES_USED = 3'd5;
   localparam logic [TYPES_BITS-1:0]     TYPES_RESET    = 3'd5;

   typedef logic [CFG_BITS-1:0] cfg_word_type;

   typedef struct packed {
      logic load;
      logic sort_step;
      logic skip;
      logic div_start;
      logic div_step;
      logic commit;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic sort_last;
      logic scan_end;
      logic fits;
      logic div_last;
      logic pend_valid;
      logic out_free;
   } status_type;

   function automatic cfg_word_type coin_reset(input int idx);
      cfg_word_type v;
      v = '0;
      unique case (idx)
         0:       v = 16'd10;
         1:       v = 16'd50;
         2:       v = 16'd5;
         3:       v = 16'd2;
         4:       v = 16'd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== sv/gcc_regs.sv =====
`default_nettype none

module gcc_regs (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [gcc_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [gcc_pkg::CFG_BITS-1:0]          csr_wdata,
   output gcc_pkg::cfg_word_type                      coin_values [gcc_pkg::COIN_REGS],
   output logic [gcc_pkg::TYPES_BITS-1:0]             types_used
);

   gcc_pkg::cfg_word_type                coin_ff [gcc_pkg::COIN_REGS];
   logic [gcc_pkg::TYPES_BITS-1:0]       types_ff;
   logic                                 wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < gcc_pkg::COIN_REGS; i++) begin
            coin_ff[i] <= gcc_pkg::coin_reset(i);
         end
         types_ff <= gcc_pkg::TYPES_RESET;
      end else if (wr) begin
         for (int i = 0; i < gcc_pkg::COIN_REGS; i++) begin
            if (csr_index == gcc_pkg::CSR_INDEX_BITS'(i)) begin
               coin_ff[i] <= csr_wdata;
            end
         end
         if (csr_index == gcc_pkg::CSR_TYPES_USED) begin
            types_ff <= csr_wdata[gcc_pkg::TYPES_BITS-1:0];
         end
      end
   end

   assign coin_values = coin_ff;
   assign types_used  = types_ff;

endmodule

`default_nettype wire

// ===== sv/gcc_dp.sv =====
`default_nettype none

module gcc_dp #(
   parameter int NUM_TYPES  = gcc_pkg::NUM_TYPES_DEFAULT,
   parameter int VALUE_BITS = gcc_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire gcc_pkg::cmd_type                  cmd,
   output gcc_pkg::status_type                    status,
   input  wire gcc_pkg::cfg_word_type             coin_values [gcc_pkg::COIN_REGS],
   input  wire logic [gcc_pkg::TYPES_BITS-1:0]    types_used,
   input  wire logic [VALUE_BITS-1:0]             req_amount,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [VALUE_BITS-1:0]                  rsp_coin_value,
   output logic [VALUE_BITS-1:0]                  rsp_coin_count,
   output logic [VALUE_BITS-1:0]                  rsp_remainder,
   output logic                                   rsp_success,
   output logic                                   rsp_last
);

   localparam int RW = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
   localparam int IW = $clog2(NUM_TYPES + 1);
   localparam int CW = $clog2(VALUE_BITS);

   logic [VALUE_BITS-1:0] rank_ff [NUM_TYPES];
   logic [VALUE_BITS-1:0] rank_in [NUM_TYPES];
   logic [VALUE_BITS-1:0] rank_swp [NUM_TYPES];
   logic [RW-1:0]         phase_ff, phase_in;
   logic [IW-1:0]         idx_ff, idx_in;
   logic [VALUE_BITS-1:0] left_ff, left_in;
   logic [VALUE_BITS-1:0] quot_ff, quot_in;
   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [VALUE_BITS-1:0] pend_value_ff, pend_value_in;
   logic [VALUE_BITS-1:0] pend_count_ff, pend_count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic [VALUE_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic [VALUE_BITS-1:0] rsp_rem_ff, rsp_rem_in;
   logic                  rsp_success_ff, rsp_success_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [VALUE_BITS-1:0] cur_rank;
   logic [VALUE_BITS:0]   trial;
   logic                  trial_ge;
   logic                  out_free;

   assign cur_rank = rank_ff[idx_ff[RW-1:0]];
   assign trial    = {rem_ff, quot_ff[VALUE_BITS-1]};
   assign trial_ge = trial >= {1'b0, cur_rank};
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rank_swp = rank_ff;
      for (int i = 0; i < NUM_TYPES - 1; i++) begin
         if (i[0] == phase_ff[0] && rank_ff[i] < rank_ff[i+1]) begin
            rank_swp[i]   = rank_ff[i+1];
            rank_swp[i+1] = rank_ff[i];
         end
      end
   end

   always_comb begin
      rank_in        = rank_ff;
      phase_in       = phase_ff;
      idx_in         = idx_ff;
      left_in        = left_ff;
      quot_in        = quot_ff;
      rem_in         = rem_ff;
      cnt_in         = cnt_ff;
      pend_valid_in  = pend_valid_ff;
      pend_value_in  = pend_value_ff;
      pend_count_in  = pend_count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_value_in   = rsp_value_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_rem_in     = rsp_rem_ff;
      rsp_success_in = rsp_success_ff;
      rsp_last_in    = rsp_last_ff;

      if (cmd.load) begin
         for (int i = 0; i < NUM_TYPES; i++) begin
            rank_in[i] = (types_used > gcc_pkg::TYPES_BITS'(i)) ?
                         VALUE_BITS'(coin_values[i]) : '0;
         end
         phase_in = '0;
         idx_in   = '0;
         left_in  = req_amount;
      end

      if (cmd.sort_step) begin
         rank_in  = rank_swp;
         phase_in = phase_ff + RW'(1);
      end

      if (cmd.skip) begin
         idx_in = idx_ff + IW'(1);
      end

      if (cmd.div_start) begin
         quot_in = left_ff;
         rem_in  = '0;
         cnt_in  = CW'(VALUE_BITS - 1);
      end

      if (cmd.div_step) begin
         rem_in  = trial_ge ? VALUE_BITS'(trial - {1'b0, cur_rank}) : trial[VALUE_BITS-1:0];
         quot_in = {quot_ff[VALUE_BITS-2:0], trial_ge};
         cnt_in  = cnt_ff - CW'(1);
      end

      if (cmd.commit) begin
         if (pend_valid_ff) begin
            rsp_valid_in   = 1'b1;
            rsp_value_in   = pend_value_ff;
            rsp_count_in   = pend_count_ff;
            rsp_rem_in     = '0;
            rsp_success_in = 1'b0;
            rsp_last_in    = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_value_in = cur_rank;
         pend_count_in = quot_ff;
         left_in       = rem_ff;
         idx_in        = idx_ff + IW'(1);
      end

      if (cmd.finish) begin
         rsp_valid_in   = 1'b1;
         rsp_value_in   = pend_valid_ff ? pend_value_ff : '0;
         rsp_count_in   = pend_valid_ff ? pend_count_ff : '0;
         rsp_rem_in     = left_ff;
         rsp_success_in = left_ff == '0;
         rsp_last_in    = 1'b1;
         pend_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rank_ff        <= rank_in;
      phase_ff       <= phase_in;
      idx_ff         <= idx_in;
      left_ff        <= left_in;
      quot_ff        <= quot_in;
      rem_ff         <= rem_in;
      cnt_ff         <= cnt_in;
      pend_value_ff  <= pend_value_in;
      pend_count_ff  <= pend_count_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_rem_ff     <= rsp_rem_in;
      rsp_success_ff <= rsp_success_in;
      rsp_last_ff    <= rsp_last_in;
   end

   always_comb begin
      status            = '0;
      status.sort_last  = phase_ff == RW'(NUM_TYPES - 1);
      status.scan_end   = idx_ff == IW'(NUM_TYPES);
      status.fits       = (cur_rank != '0) && (left_ff >= cur_rank);
      status.div_last   = cnt_ff == '0;
      status.pend_valid = pend_valid_ff;
      status.out_free   = out_free;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_coin_value = rsp_value_ff;
   assign rsp_coin_count = rsp_count_ff;
   assign rsp_remainder  = rsp_rem_ff;
   assign rsp_success    = rsp_success_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire

// ===== sv/gcc_ctrl.sv =====
`default_nettype none

`include "greedy_coin_change_top_defines.svh"

module gcc_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire gcc_pkg::status_type   status,
   output gcc_pkg::cmd_type           cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SORT   = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_COMMIT = 3'd4;
   localparam logic [2:0] S_FINAL  = 3'd5;

   logic [2:0] state_ff, state_in;

   assign req_ready = state_ff == S_IDLE;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SORT;
            end
         end
         S_SORT: begin
            cmd.sort_step = 1'b1;
            if (status.sort_last) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (status.scan_end) begin
               state_in = S_FINAL;
            end else if (status.fits) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               cmd.skip = 1'b1;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (!status.pend_valid || status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_SCAN;
            end
         end
         S_FINAL: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `GCC_ASSERT_NOW(a_idle_no_pend, state_ff == S_IDLE, !status.pend_valid, "pending beat left in idle")
   `GCC_ASSERT_NOW(a_commit_free, cmd.commit && status.pend_valid, status.out_free, "commit overwrites output")
   `GCC_ASSERT_NOW(a_finish_free, cmd.finish, status.out_free, "final beat overwrites output")
   `GCC_ASSERT_NEXT(a_div_exit, state_ff == S_DIV, state_ff == S_DIV || state_ff == S_COMMIT, "divide left early")

endmodule

`default_nettype wire

// ===== sv/greedy_coin_change_top.sv =====
// Greedy coin change. Each amount beat is split over the active denominations, largest first;
// one result beat leaves per denomination that contributes a coin, and the final beat (last set)
// carries the remainder and success flag. One amount is handled at a time: acceptance, odd-even
// ranking, a scan over the denominations that closes once past the last one, plus, for each
// denomination that fits, a division on the shared restoring divider and a commit, then a final
// step. Commit and final steps wait while the result channel stalls. A finished result waits
// in the output register while the next amount is accepted. Configuration writes take effect on
// the next amount.
`default_nettype none

module greedy_coin_change_top #(
   parameter int NUM_TYPES  = gcc_pkg::NUM_TYPES_DEFAULT,
   parameter int VALUE_BITS = gcc_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [VALUE_BITS-1:0]              req_amount,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [VALUE_BITS-1:0]                   rsp_coin_value,
   output logic [VALUE_BITS-1:0]                   rsp_coin_count,
   output logic [VALUE_BITS-1:0]                   rsp_remainder,
   output logic                                    rsp_success,
   output logic                                    rsp_last,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [gcc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [gcc_pkg::CFG_BITS-1:0]       csr_wdata
);

   gcc_pkg::cfg_word_type              coin_values [gcc_pkg::COIN_REGS];
   logic [gcc_pkg::TYPES_BITS-1:0]     types_used;
   gcc_pkg::cmd_type                   cmd;
   gcc_pkg::status_type                status;

   gcc_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .coin_values (coin_values),
      .types_used  (types_used)
   );

   gcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gcc_dp #(
      .NUM_TYPES  (NUM_TYPES),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .coin_values    (coin_values),
      .types_used     (types_used),
      .req_amount     (req_amount),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_coin_value (rsp_coin_value),
      .rsp_coin_count (rsp_coin_count),
      .rsp_remainder  (rsp_remainder),
      .rsp_success    (rsp_success),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

// ===== verif/coin_change_checker.sv =====
`timescale 1ns / 1ps

module coin_change_checker #(
   parameter int NUM_TYPES  = gcc_pkg::NUM_TYPES_DEFAULT,
   parameter int VALUE_BITS = gcc_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   input  wire logic                               req_ready,
   input  wire logic [VALUE_BITS-1:0]              req_amount,
   input  wire logic                               rsp_valid,
   input  wire logic                               rsp_ready,
   input  wire logic [VALUE_BITS-1:0]              rsp_coin_value,
   input  wire logic [VALUE_BITS-1:0]              rsp_coin_count,
   input  wire logic [VALUE_BITS-1:0]              rsp_remainder,
   input  wire logic                               rsp_success,
   input  wire logic                               rsp_last,
   input  wire logic                               csr_valid,
   input  wire logic                               csr_ready,
   input  wire logic [gcc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [gcc_pkg::CFG_BITS-1:0]       csr_wdata,
   output int                                      outstanding,
   output int                                      failures
);

   localparam int COIN_REGS = gcc_pkg::COIN_REGS;
   localparam logic [VALUE_BITS-1:0] COIN_DEFAULTS [COIN_REGS] = '{10, 50, 5, 2, 1};

   typedef struct packed {
      logic [VALUE_BITS-1:0] coin_value;
      logic [VALUE_BITS-1:0] coin_count;
      logic [VALUE_BITS-1:0] remainder;
      logic                  success;
      logic                  last;
   } coin_beat_type;

   coin_beat_type                   change_q [$];
   coin_beat_type                   want;
   logic [VALUE_BITS-1:0]           coin_reg [COIN_REGS];
   logic [gcc_pkg::TYPES_BITS-1:0]  types_used;

   // Rank the active denominations, largest first, and take as many of each as fit.
   function automatic void queue_change(input logic [VALUE_BITS-1:0] amount);
      logic [VALUE_BITS-1:0] ranked [COIN_REGS];
      logic [VALUE_BITS-1:0] left;
      logic [VALUE_BITS-1:0] key;
      logic [VALUE_BITS-1:0] cnt;
      coin_beat_type         beat;
      int                    n;
      int                    i;
      int                    j;
      int                    made;
      n = (int'(types_used) > NUM_TYPES) ? NUM_TYPES : int'(types_used);
      if (n > COIN_REGS) n = COIN_REGS;
      for (i = 0; i < n; i++) ranked[i] = coin_reg[i];
      for (i = 1; i < n; i++) begin
         key = ranked[i];
         j   = i - 1;
         while (j >= 0) begin
            if (ranked[j] >= key) break;
            ranked[j + 1] = ranked[j];
            j--;
         end
         ranked[j + 1] = key;
      end
      left = amount;
      made = 0;
      for (i = 0; i < n; i++) begin
         if (ranked[i] != '0 && left >= ranked[i]) begin
            cnt             = left / ranked[i];
            left            = left - cnt * ranked[i];
            beat            = '0;
            beat.coin_value = ranked[i];
            beat.coin_count = cnt;
            change_q.push_back(beat);
            made++;
         end
      end
      if (made == 0) change_q.push_back('0);
      beat           = change_q.pop_back();
      beat.remainder = left;
      beat.success   = (left == '0);
      beat.last      = 1'b1;
      change_q.push_back(beat);
   endfunction

   function automatic void check_field(input string name, input logic [VALUE_BITS-1:0] exp_v,
                                       input logic [VALUE_BITS-1:0] got_v);
      if (got_v !== exp_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, got_v);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COIN_REGS; i++) coin_reg[i] = COIN_DEFAULTS[i];
         types_used = gcc_pkg::TYPES_RESET;
         change_q.delete();
         failures = 0;
         outstanding <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index < gcc_pkg::CSR_INDEX_BITS'(COIN_REGS)) begin
               coin_reg[csr_index] = VALUE_BITS'(csr_wdata);
            end else if (csr_index == gcc_pkg::CSR_TYPES_USED) begin
               types_used = csr_wdata[gcc_pkg::TYPES_BITS-1:0];
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (change_q.size() == 0) begin
               $error("unexpected result beat: coin_value %0d, coin_count %0d, last %0b",
                      rsp_coin_value, rsp_coin_count, rsp_last);
               failures++;
            end else begin
               want = change_q.pop_front();
               check_field("coin_value", want.coin_value, rsp_coin_value);
               check_field("coin_count", want.coin_count, rsp_coin_count);
               check_field("remainder", want.remainder, rsp_remainder);
               check_field("success", VALUE_BITS'(want.success), VALUE_BITS'(rsp_success));
               check_field("last", VALUE_BITS'(want.last), VALUE_BITS'(rsp_last));
            end
         end
         if (req_valid && req_ready) queue_change(req_amount);
         outstanding <= change_q.size();
      end
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam int VALUE_BITS     = gcc_pkg::VALUE_BITS_DEFAULT;
   localparam int IDX_BITS       = gcc_pkg::CSR_INDEX_BITS;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 200;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_ITEMS    = 17;

   localparam logic [IDX_BITS-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [IDX_BITS-1:0] CSR_SPARE_HI = 3'd7;

   typedef enum {STALL_NONE, STALL_COIN_FLIP, STALL_ONE_IN_FOUR, STALL_LONG} stall_mode_type;

   logic                          clock          = 1'b0;
   logic                          reset          = 1'b1;
   logic                          req_valid      = 1'b0;
   logic                          req_ready;
   logic [VALUE_BITS-1:0]         req_amount     = '0;
   logic                          rsp_valid;
   logic                          rsp_ready      = 1'b0;
   logic [VALUE_BITS-1:0]         rsp_coin_value;
   logic [VALUE_BITS-1:0]         rsp_coin_count;
   logic [VALUE_BITS-1:0]         rsp_remainder;
   logic                          rsp_success;
   logic                          rsp_last;
   logic                          csr_valid      = 1'b0;
   logic                          csr_ready;
   logic [IDX_BITS-1:0]           csr_index      = '0;
   logic [gcc_pkg::CFG_BITS-1:0]  csr_wdata      = '0;

   int             outstanding;
   int             failures;
   int             burst_left  = 4;
   int             idle_cycles = 0;
   int             mode_left   = 0;
   int             stall_hold  = 0;
   int             stall_tick  = 0;
   stall_mode_type stall_mode  = STALL_NONE;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   greedy_coin_change_top i_dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_amount,
      .rsp_valid, .rsp_ready, .rsp_coin_value, .rsp_coin_count, .rsp_remainder,
      .rsp_success, .rsp_last,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   coin_change_checker i_change_checker (
      .clock, .reset,
      .req_valid, .req_ready, .req_amount,
      .rsp_valid, .rsp_ready, .rsp_coin_value, .rsp_coin_count, .rsp_remainder,
      .rsp_success, .rsp_last,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .outstanding, .failures
   );

   // Result side back-pressure: switch pattern every so often.
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(20, 120);
      end
      mode_left  = mode_left - 1;
      stall_tick = stall_tick + 1;
      case (stall_mode)
         STALL_NONE:        rsp_ready <= 1'b1;
         STALL_COIN_FLIP:   rsp_ready <= 1'($urandom_range(0, 1));
         STALL_ONE_IN_FOUR: rsp_ready <= (stall_tick % 4 == 0);
         default: begin
            if (stall_hold > 0) begin
               stall_hold = stall_hold - 1;
               rsp_ready <= 1'b0;
            end else begin
               if ($urandom_range(0, 3) == 0) stall_hold = $urandom_range(5, 15);
               rsp_ready <= 1'b1;
            end
         end
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic write_csr(input logic [IDX_BITS-1:0] idx, input logic [15:0] data,
                            input bit keep_valid);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (!keep_valid) csr_valid <= 1'b0;
   endtask

   task automatic apply_coins(input logic [15:0] c0, input logic [15:0] c1,
                              input logic [15:0] c2, input logic [15:0] c3,
                              input logic [15:0] c4, input logic [15:0] types_word);
      logic [15:0] coins [gcc_pkg::COIN_REGS];
      coins = '{c0, c1, c2, c3, c4};
      for (int i = 0; i < gcc_pkg::COIN_REGS; i++) write_csr(IDX_BITS'(i), coins[i], 1'b1);
      write_csr(gcc_pkg::CSR_TYPES_USED, types_word, 1'b0);
   endtask

   // Hold valid across a burst; drop it and idle between bursts.
   task automatic send_amount(input logic [VALUE_BITS-1:0] amount);
      req_valid  <= 1'b1;
      req_amount <= amount;
      do @(posedge clock); while (!req_ready);
      burst_left = burst_left - 1;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(1, 6);
      end
   endtask

   task automatic finish_phase();
      if (req_valid) req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   function automatic logic [15:0] rand_coin();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 2) return '0;
      if (pick < 4) return 16'($urandom());
      return 16'($urandom_range(1, 100));
   endfunction

   function automatic logic [VALUE_BITS-1:0] rand_amount();
      if ($urandom_range(0, 1) == 1) return VALUE_BITS'($urandom());
      return VALUE_BITS'($urandom_range(0, 600));
   endfunction

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset denominations
      send_amount(0);
      send_amount(1);
      send_amount(65535);
      send_amount(88);
      send_amount(7);
      send_amount(3);
      finish_phase();

      // writes to unmapped indexes change nothing
      write_csr(CSR_SPARE_LO, 16'($urandom()), 1'b1);
      write_csr(CSR_SPARE_HI, 16'($urandom()), 1'b0);
      send_amount(37);
      finish_phase();

      // every denomination zero
      apply_coins(0, 0, 0, 0, 0, 16'(gcc_pkg::TYPES_RESET));
      send_amount(0);
      send_amount(9);
      finish_phase();

      // largest values, duplicates, type count above the limit
      apply_coins(16'hFFFF, 16'hFFFF, 1, 0, 16'h8000, 16'h0007);
      send_amount(65535);
      send_amount(65534);
      send_amount(32768);
      send_amount(32767);
      finish_phase();

      // no denomination takes part
      apply_coins(3, 4, 5, 6, 7, 16'h0000);
      send_amount(0);
      send_amount(12);
      finish_phase();

      // single denomination, remainder left over
      apply_coins(7, 300, 4, 0, 9, 16'hFFF9);
      send_amount(20);
      send_amount(5);
      finish_phase();

      // upper bits of the type count ignored
      apply_coins(6, 4, 16'hFFFF, 0, 16'hAAAA, 16'hFFFE);
      send_amount(9);
      send_amount(8);
      finish_phase();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         apply_coins(rand_coin(), rand_coin(), rand_coin(), rand_coin(), rand_coin(),
                     ($urandom_range(0, 1) == 1) ? {13'($urandom()), gcc_pkg::TYPES_RESET}
                                                 : 16'($urandom()));
         for (int k = 0; k < PHASE_ITEMS; k++) send_amount(rand_amount());
         finish_phase();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/gcc_pkg.sv
sv/gcc_regs.sv
sv/gcc_dp.sv
sv/gcc_ctrl.sv
sv/greedy_coin_change_top.sv
verif/coin_change_checker.sv
verif/testbench.sv
